### sv/texture_tile_address_mapper_top_macros.svh
// Assertion macros shared by the checker of the tile address mapper.
`ifndef TEXTURE_TILE_ADDRESS_MAPPER_TOP_MACROS_SVH
`define TEXTURE_TILE_ADDRESS_MAPPER_TOP_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define TTAM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define TTAM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/ttam_pkg.sv
// Shared widths, limits and register indexes of the texture tile address mapper.
package ttam_pkg;

  localparam int IDX_W      = 28;
  localparam int DATA_W     = 32;
  localparam int CNT_W      = 12;
  localparam int DIM_W      = 13;
  localparam int STRIDE_W   = 16;
  localparam int EB_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_TDATA_W = 2 * IDX_W + DATA_W;

  localparam int MAX_DIM = 4096;
  localparam int TILE_W  = 4;
  localparam int TILE_H  = 4;

  localparam int XTILE_W   = DIM_W - 2;
  localparam int TILEROW_W = XTILE_W + 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION    = 3'd0,
    CFG_IMAGE_WIDTH  = 3'd1,
    CFG_IMAGE_HEIGHT = 3'd2,
    CFG_STRIDE_BYTES = 3'd3,
    CFG_ELEMENT_SIZE = 3'd4
  } cfg_reg_t;

  typedef enum logic [EB_W-1:0] {
    EB_ONE  = 3'd1,
    EB_TWO  = 3'd2,
    EB_FOUR = 3'd4
  } elem_size_t;

  localparam logic DIR_LIN_TO_TILE = 1'b0;

endpackage

### sv/texture_tile_address_mapper_top.sv
// Linear / 4x4-tiled texture copy address generator, top level.
// Output: a request accepted at a clock edge is registered and shows on out_tvalid in the cycle after it.
// Throughput: one request per cycle while out_tready is high; the single output register refills as it drains.
// Critical path: a 12x16 multiply and add from the row/column counters to the result register.
// Reset (rst_n low, synchronous): counters to 0, output empty, registers to their defaults.
module texture_tile_address_mapper_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [ttam_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ttam_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [ttam_pkg::DATA_W-1:0]           in_tdata,   // element_data
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [ttam_pkg::OUT_TDATA_W-1:0]      out_tdata,  // source_index, dest_index, out_data
  output logic                                  out_tlast,  // is_last
  output logic                                  out_tuser   // unsupported
);
  import ttam_pkg::*;

  logic                  direction_r;
  logic [DIM_W-1:0]      width_cfg_r;
  logic [DIM_W-1:0]      height_cfg_r;
  logic [STRIDE_W-1:0]   stride_bytes_r;
  logic [EB_W-1:0]       elem_bytes_r;

  logic [CNT_W-1:0]      col_r, col_nxt;
  logic [CNT_W-1:0]      row_r, row_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]      src_r, src_nxt;
  logic [IDX_W-1:0]      dst_r, dst_nxt;
  logic [DATA_W-1:0]     data_r;
  logic                  last_r, last_nxt;
  logic                  unsup_r, unsup_nxt;

  logic                  accept;
  logic [DIM_W-1:0]      w_eff, h_eff;
  logic                  col_end, row_end;
  logic [STRIDE_W-1:0]   stride_elems;
  logic [XTILE_W-1:0]    xtiles;
  logic [TILEROW_W-1:0]  tile_row;
  logic [IDX_W-1:0]      lin_idx, til_idx;

  // Clamp dimensions to 1..MAX_DIM.
  always_comb begin
    if (width_cfg_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_cfg_r > DIM_W'(MAX_DIM)) begin
      w_eff = DIM_W'(MAX_DIM);
    end else begin
      w_eff = width_cfg_r;
    end
    if (height_cfg_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_cfg_r > DIM_W'(MAX_DIM)) begin
      h_eff = DIM_W'(MAX_DIM);
    end else begin
      h_eff = height_cfg_r;
    end
  end

  assign col_end = ({1'b0, col_r} + DIM_W'(1)) >= w_eff;
  assign row_end = ({1'b0, row_r} + DIM_W'(1)) >= h_eff;

  always_comb begin
    unsup_nxt    = 1'b0;
    stride_elems = stride_bytes_r;
    case (elem_bytes_r)
      EB_FOUR: stride_elems = stride_bytes_r >> 2;
      EB_TWO:  stride_elems = stride_bytes_r >> 1;
      EB_ONE:  stride_elems = stride_bytes_r;
      default: unsup_nxt    = 1'b1;
    endcase
  end

  assign xtiles   = XTILE_W'((w_eff + DIM_W'(TILE_W - 1)) / TILE_W);
  assign tile_row = TILEROW_W'(xtiles) * TILEROW_W'(TILE_W * TILE_H);

  assign lin_idx = IDX_W'(row_r) * IDX_W'(stride_elems) + IDX_W'(col_r);
  assign til_idx = IDX_W'(row_r / TILE_H) * IDX_W'(tile_row)
                 + IDX_W'((row_r % TILE_H) * TILE_W)
                 + IDX_W'((col_r / TILE_W) * (TILE_W * TILE_H))
                 + IDX_W'(col_r % TILE_W);

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    if (unsup_nxt) begin
      src_nxt = '0;
      dst_nxt = '0;
    end else if (direction_r == DIR_LIN_TO_TILE) begin
      src_nxt = lin_idx;
      dst_nxt = til_idx;
    end else begin
      src_nxt = til_idx;
      dst_nxt = lin_idx;
    end
    last_nxt = col_end && row_end;

    // Advance raster position; a counter past a shrunk dimension wraps.
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end

    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r    <= DIR_LIN_TO_TILE;
      width_cfg_r    <= DIM_W'(1);
      height_cfg_r   <= DIM_W'(1);
      stride_bytes_r <= '0;
      elem_bytes_r   <= EB_FOUR;
      col_r          <= '0;
      row_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIRECTION:    direction_r    <= cfg_wdata[0];
          CFG_IMAGE_WIDTH:  width_cfg_r    <= cfg_wdata[DIM_W-1:0];
          CFG_IMAGE_HEIGHT: height_cfg_r   <= cfg_wdata[DIM_W-1:0];
          CFG_STRIDE_BYTES: stride_bytes_r <= cfg_wdata[STRIDE_W-1:0];
          CFG_ELEMENT_SIZE: elem_bytes_r   <= cfg_wdata[EB_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload: load on each accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      data_r  <= in_tdata;
      last_r  <= last_nxt;
      unsup_r <= unsup_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {data_r, dst_r, src_r};
  assign out_tlast  = last_r;
  assign out_tuser  = unsup_r;

endmodule

### sv/ttam_checker.sv
// Port-level checker for the texture tile address mapper, bound to the top level.
`include "texture_tile_address_mapper_top_macros.svh"

module ttam_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  cfg_we,
  input logic [ttam_pkg::CFG_IDX_W-1:0]        cfg_index,
  input logic [ttam_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input logic                                  in_tvalid,
  input logic                                  in_tready,
  input logic [ttam_pkg::DATA_W-1:0]           in_tdata,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [ttam_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input logic                                  out_tlast,
  input logic                                  out_tuser
);
  import ttam_pkg::*;

  // Stalled result keeps its payload.
  `TTAM_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled result changed")
  // An empty output stage must take a request.
  `TTAM_ASSERT(a_ready_when_empty, clk, rst_n, !out_tvalid |-> in_tready, "input blocked with empty output")
  // An accepted request appears with its data on the next cycle.
  `TTAM_ASSERT(a_data_passthru, clk, rst_n, in_tvalid && in_tready |=> out_tvalid && out_tdata[OUT_TDATA_W-1:2*IDX_W] == $past(in_tdata), "data not passed through")
  // Unsupported size gives zero indices.
  `TTAM_ASSERT(a_unsup_zero, clk, rst_n, out_tvalid && out_tuser |-> out_tdata[2*IDX_W-1:0] == '0, "unsupported result has nonzero index")
  `TTAM_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind texture_tile_address_mapper_top ttam_checker u_ttam_checker (.*);
